/* rtl/core/hpt_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers of the compensation block
// no dependencies; imported by hpt_alu, hpt_csr, hpt_seq and the top module
package hpt_pkg;

   // datapath width: widest product is the divisor term, below 2^71 in magnitude
   localparam int DP_W       = 72;
   localparam int ALU_B_W    = 64;
   localparam int ALU_CNT_W  = 7;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef logic signed [DP_W-1:0] dp_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic                 start;
      alu_op_type           op;
      logic [ALU_CNT_W-1:0] count;
   } alu_ctl_type;

   typedef struct packed {
      logic   done;
      dp_type res;
   } alu_rsp_type;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_TEMP = 3'd0,
      REG_PLO  = 3'd1,
      REG_PHI  = 3'd2,
      REG_P9   = 3'd3,
      REG_HUM  = 3'd4
   } reg_idx_type;

   // unpacked calibration coefficients
   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
      logic         [7:0] h1;
      logic signed [15:0] h2;
      logic         [7:0] h3;
      logic signed [11:0] h4;
      logic signed [11:0] h5;
      logic signed  [7:0] h6;
   } coeff_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_WAIT,
      SEQ_RESP
   } seq_state_type;

   typedef enum logic [4:0] {
      ST_T1, ST_T2, ST_T3,
      ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
      ST_P7, ST_P8, ST_P9, ST_P10, ST_P11,
      ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8
   } step_type;

   // arithmetic constants
   localparam dp_type TEMP_LO  = -72'sd4000;
   localparam dp_type TEMP_HI  = 72'sd8500;
   localparam dp_type T_RND    = 72'sd128;
   localparam dp_type PV_OFS   = 72'sd128000;
   localparam dp_type HV_OFS   = 72'sd76800;
   localparam dp_type BASE47   = 72'sd140737488355328;
   localparam dp_type NUM_LIM  = 72'sd2951479051793528;
   localparam dp_type PP_LIM   = 72'sd34359738368;
   localparam dp_type PRESS_LO = 72'sd7680000;
   localparam dp_type PRESS_HI = 72'sd28160000;
   localparam dp_type H_RND1   = 72'sd16384;
   localparam dp_type H_OFS2   = 72'sd32768;
   localparam dp_type H_OFS3   = 72'sd2097152;
   localparam dp_type H_RND2   = 72'sd8192;
   localparam dp_type U_LIM    = 72'sd4294967296;
   localparam dp_type SQ_LIM   = 72'sh00_8000_0000_0000_0000;
   localparam dp_type HUM_CAP  = 72'sd419430400;
   localparam dp_type DP_ONE_N = -72'sd1;
   localparam logic [20:0] PP_BASE = 21'd1048576;

   // sign extension of a narrow operand into the datapath
   function automatic dp_type to_dp(input logic signed [35:0] x);
      return DP_W'(x);
   endfunction

   function automatic dp_type abs_dp(input dp_type x);
      return x[DP_W-1] ? -x : x;
   endfunction

   // left-align an n-bit signed multiplier for msb-first scanning
   function automatic logic [ALU_B_W-1:0] align_b(input dp_type v,
                                                  input logic [ALU_CNT_W-1:0] n);
      logic [ALU_B_W-1:0] t;
      t = ALU_B_W'(v);
      return t << (ALU_CNT_W'(ALU_B_W) - n);
   endfunction

   // clamp the humidity term and drop its 12 low bits
   function automatic logic [16:0] hum_clamp(input dp_type y);
      dp_type c;
      c = y;
      if (y[DP_W-1]) begin
         c = '0;
      end else if (y > HUM_CAP) begin
         c = HUM_CAP;
      end
      return 17'(c >>> 12);
   endfunction

endpackage

/* rtl/core/hpt_req_if.sv */
`timescale 1ns / 1ps
// raw reading channel: valid/ready handshake plus the three converter values
// standalone interface, no dependencies
interface hpt_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temp;
   logic [19:0] raw_press;
   logic [15:0] raw_hum;

   modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
   modport sink (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

/* rtl/core/hpt_rsp_if.sv */
`timescale 1ns / 1ps
// compensated result channel: valid/ready handshake plus the result fields
// standalone interface, no dependencies
interface hpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] temp_centi;
   logic        [24:0] press_q8;
   logic        [16:0] hum_q10;
   logic               temp_held;
   logic               press_held;

   modport source (output valid, temp_centi, press_q8, hum_q10, temp_held, press_held,
                   input ready);
   modport sink (input valid, temp_centi, press_q8, hum_q10, temp_held, press_held,
                 output ready);
endinterface

/* rtl/core/hpt_alu.sv */
`timescale 1ns / 1ps
// shared shift-add multiplier / restoring divider, one bit per cycle
// depends on hpt_pkg
module hpt_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  hpt_pkg::alu_ctl_type          ctl,
   input  hpt_pkg::dp_type               a,
   input  logic [hpt_pkg::ALU_B_W-1:0]   b,
   output hpt_pkg::alu_rsp_type          rsp
);
   import hpt_pkg::*;

   dp_type               acc_ff, acc_in;
   dp_type               a_ff, a_in;
   logic [ALU_B_W-1:0]   b_ff, b_in;
   logic [ALU_CNT_W-1:0] cnt_ff, cnt_in;
   alu_op_type           op_ff, op_in;
   logic                 first_ff, first_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   dp_type lhs;
   dp_type opnd;
   dp_type sum;
   logic   is_div;
   logic   sub;
   logic   qbit;

   // one adder: acc*2 +/- a for multiply, rem*2+bit - divisor for divide
   always_comb begin
      is_div = (op_ff == ALU_DIV);
      lhs    = is_div ? {acc_ff[DP_W-2:0], b_ff[ALU_B_W-1]} : {acc_ff[DP_W-2:0], 1'b0};
      sub    = is_div | (b_ff[ALU_B_W-1] & first_ff);
      opnd   = (is_div | b_ff[ALU_B_W-1]) ? a_ff : '0;
      sum    = lhs + (sub ? ~opnd : opnd) + DP_W'(sub);
      qbit   = is_div & ~sum[DP_W-1];
   end

   // iteration control
   always_comb begin
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      first_in = first_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         acc_in   = '0;
         a_in     = a;
         b_in     = b;
         cnt_in   = ctl.count;
         op_in    = ctl.op;
         first_in = 1'b1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = (is_div & sum[DP_W-1]) ? lhs : sum;
         b_in     = {b_ff[ALU_B_W-2:0], qbit};
         cnt_in   = cnt_ff - ALU_CNT_W'(1);
         first_in = 1'b0;
         if (cnt_ff == ALU_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      first_ff <= first_in;
   end

   // quotient sits in the low bits of the shift register
   assign rsp.done = done_ff;
   assign rsp.res  = (op_ff == ALU_DIV) ? DP_W'({1'b0, b_ff[ALU_B_W-2:0]}) : acc_ff;

endmodule

/* rtl/core/hpt_csr.sv */
`timescale 1ns / 1ps
// calibration coefficient registers behind the apb-style port
// depends on hpt_pkg
module hpt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hpt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hpt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hpt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output hpt_pkg::coeff_type               coeff
);
   import hpt_pkg::*;

   logic [47:0] temp_ff, temp_in;
   logic [63:0] plo_ff, plo_in;
   logic [63:0] phi_ff, phi_in;
   logic [15:0] p9_ff, p9_in;
   logic [63:0] hum_ff, hum_in;
   logic        wr_en;
   reg_idx_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = reg_idx_type'(paddr[5:3]);

   // write decode
   always_comb begin
      temp_in = temp_ff;
      plo_in  = plo_ff;
      phi_in  = phi_ff;
      p9_in   = p9_ff;
      hum_in  = hum_ff;
      if (wr_en) begin
         unique case (idx)
            REG_TEMP: temp_in = pwdata[47:0];
            REG_PLO:  plo_in  = pwdata;
            REG_PHI:  phi_in  = pwdata;
            REG_P9:   p9_in   = pwdata[15:0];
            REG_HUM:  hum_in  = pwdata;
            default:  temp_in = temp_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_TEMP: prdata = {16'd0, temp_ff};
         REG_PLO:  prdata = plo_ff;
         REG_PHI:  prdata = phi_ff;
         REG_P9:   prdata = {48'd0, p9_ff};
         REG_HUM:  prdata = hum_ff;
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0;
         plo_ff  <= '0;
         phi_ff  <= '0;
         p9_ff   <= '0;
         hum_ff  <= '0;
      end else begin
         temp_ff <= temp_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         p9_ff   <= p9_in;
         hum_ff  <= hum_in;
      end
   end

   // coefficient fields
   assign coeff.t1 = temp_ff[15:0];
   assign coeff.t2 = temp_ff[31:16];
   assign coeff.t3 = temp_ff[47:32];
   assign coeff.p1 = plo_ff[15:0];
   assign coeff.p2 = plo_ff[31:16];
   assign coeff.p3 = plo_ff[47:32];
   assign coeff.p4 = plo_ff[63:48];
   assign coeff.p5 = phi_ff[15:0];
   assign coeff.p6 = phi_ff[31:16];
   assign coeff.p7 = phi_ff[47:32];
   assign coeff.p8 = phi_ff[63:48];
   assign coeff.p9 = p9_ff;
   assign coeff.h1 = hum_ff[7:0];
   assign coeff.h2 = hum_ff[23:8];
   assign coeff.h3 = hum_ff[31:24];
   assign coeff.h4 = hum_ff[43:32];
   assign coeff.h5 = hum_ff[55:44];
   assign coeff.h6 = hum_ff[63:56];

endmodule

/* rtl/core/hpt_seq.sv */
`timescale 1ns / 1ps
// step sequencer: feeds the shared alu, folds each product into the formulas
// depends on hpt_pkg, hpt_req_if, hpt_rsp_if
module hpt_seq (
   input  logic                          clock,
   input  logic                          reset,
   hpt_req_if.sink                       req,
   hpt_rsp_if.source                     rsp,
   input  hpt_pkg::coeff_type            coeff,
   output hpt_pkg::alu_ctl_type          alu_ctl,
   output hpt_pkg::dp_type               alu_a,
   output logic [hpt_pkg::ALU_B_W-1:0]   alu_b,
   input  hpt_pkg::alu_rsp_type          alu_rsp
);
   import hpt_pkg::*;

   seq_state_type      state_ff, state_in;
   step_type           step_ff, step_in;
   logic        [19:0] rt_ff, rt_in;
   logic        [19:0] rp_ff, rp_in;
   logic        [15:0] rh_ff, rh_in;
   logic signed [24:0] fine_ff, fine_in;
   dp_type             r0_ff, r0_in;
   dp_type             r1_ff, r1_in;
   dp_type             r2_ff, r2_in;
   logic signed [14:0] last_temp_ff, last_temp_in;
   logic        [24:0] last_press_ff, last_press_in;
   logic signed [14:0] temp_out_ff, temp_out_in;
   logic        [24:0] press_out_ff, press_out_in;
   logic        [16:0] hum_out_ff, hum_out_in;
   logic               th_ff, th_in;
   logic               ph_ff, ph_in;

   dp_type                pv;
   dp_type                hv;
   dp_type                r0_mag;
   dp_type                op_a;
   dp_type                op_b;
   logic [ALU_CNT_W-1:0]  op_n;
   alu_op_type            op_code;
   logic                  consume;
   logic                  finish;
   dp_type                res;
   dp_type                fine_v;
   dp_type                tc_v;
   dp_type                num_v;
   dp_type                pp_v;
   dp_type                pr_v;
   dp_type                u_v;
   dp_type                y_v;
   logic                  tbad;
   logic                  pbad;

   assign pv      = to_dp(36'(fine_ff)) - PV_OFS;
   assign hv      = to_dp(36'(fine_ff)) - HV_OFS;
   assign r0_mag  = abs_dp(r0_ff);
   assign res     = alu_rsp.res;
   assign consume = (state_ff == SEQ_WAIT) & alu_rsp.done;

   // operand select per step
   always_comb begin
      op_a    = r1_ff;
      op_b    = '0;
      op_n    = ALU_CNT_W'(16);
      op_code = ALU_MUL;
      unique case (step_ff)
         ST_T1: begin
            op_a = to_dp(36'(rt_ff >> 3)) - (to_dp(36'(coeff.t1)) <<< 1);
            op_b = to_dp(36'(coeff.t2));
         end
         ST_T2: begin
            op_a = to_dp(36'(rt_ff >> 4)) - to_dp(36'(coeff.t1));
            op_b = op_a;
            op_n = ALU_CNT_W'(17);
         end
         ST_T3: begin
            op_a = r1_ff;
            op_b = to_dp(36'(coeff.t3));
         end
         ST_P1: begin
            op_a = pv;
            op_b = pv;
            op_n = ALU_CNT_W'(25);
         end
         ST_P2: begin
            op_a = r0_ff;
            op_b = to_dp(36'(coeff.p6));
         end
         ST_P3: begin
            op_a = pv;
            op_b = to_dp(36'(coeff.p5));
         end
         ST_P4: begin
            op_a = r0_ff;
            op_b = to_dp(36'(coeff.p3));
         end
         ST_P5: begin
            op_a = pv;
            op_b = to_dp(36'(coeff.p2));
         end
         ST_P6: begin
            op_a = r2_ff;
            op_b = to_dp(36'(coeff.p1));
            op_n = ALU_CNT_W'(17);
         end
         ST_P7: begin
            op_a = r0_ff;
            op_b = 72'sd3125;
            op_n = ALU_CNT_W'(13);
         end
         ST_P8: begin
            op_a    = abs_dp(r2_ff);
            op_n    = ALU_CNT_W'(63);
            op_code = ALU_DIV;
         end
         ST_P9: begin
            op_a = r0_ff >>> 13;
            op_b = op_a;
            op_n = ALU_CNT_W'(23);
         end
         ST_P10: begin
            op_a = r1_ff;
            op_b = to_dp(36'(coeff.p9));
         end
         ST_P11: begin
            op_a = r0_ff;
            op_b = to_dp(36'(coeff.p8));
         end
         ST_H1: begin
            op_a = hv;
            op_b = to_dp(36'(coeff.h5));
            op_n = ALU_CNT_W'(12);
         end
         ST_H2: begin
            op_a = hv;
            op_b = to_dp(36'(coeff.h6));
            op_n = ALU_CNT_W'(8);
         end
         ST_H3: begin
            op_a = hv;
            op_b = to_dp(36'(coeff.h3));
            op_n = ALU_CNT_W'(9);
         end
         ST_H4: begin
            op_a = r1_ff;
            op_b = r2_ff;
            op_n = ALU_CNT_W'(22);
         end
         ST_H5: begin
            op_a = r1_ff;
            op_b = to_dp(36'(coeff.h2));
         end
         ST_H6: begin
            op_a = r1_ff;
            op_b = r0_ff;
            op_n = ALU_CNT_W'(22);
         end
         ST_H7: begin
            op_a = r1_ff;
            op_b = r1_ff;
            op_n = ALU_CNT_W'(33);
         end
         ST_H8: begin
            op_a = r1_ff;
            op_b = to_dp(36'(coeff.h1));
            op_n = ALU_CNT_W'(9);
         end
         default: begin
            op_a = r1_ff;
         end
      endcase
   end

   // dividend magnitude goes msb-first, left-aligned above the quotient slot
   assign alu_a = op_a;
   assign alu_b = (op_code == ALU_DIV) ? {r0_mag[ALU_B_W-2:0], 1'b0} : align_b(op_b, op_n);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE:  if (req.valid) state_in = SEQ_ISSUE;
         SEQ_ISSUE: state_in = SEQ_WAIT;
         SEQ_WAIT: begin
            if (alu_rsp.done) begin
               state_in = finish ? SEQ_RESP : SEQ_ISSUE;
            end
         end
         SEQ_RESP:  if (rsp.ready) state_in = SEQ_IDLE;
         default:   state_in = SEQ_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req.ready     = 1'b0;
      rsp.valid     = 1'b0;
      alu_ctl.start = 1'b0;
      alu_ctl.op    = op_code;
      alu_ctl.count = op_n;
      unique case (state_ff)
         SEQ_IDLE:  req.ready     = 1'b1;
         SEQ_ISSUE: alu_ctl.start = 1'b1;
         SEQ_WAIT:  req.ready     = 1'b0;
         SEQ_RESP:  rsp.valid     = 1'b1;
         default:   req.ready     = 1'b0;
      endcase
   end

   // datapath: fold each finished product into the formulas
   always_comb begin
      step_in       = step_ff;
      rt_in         = rt_ff;
      rp_in         = rp_ff;
      rh_in         = rh_ff;
      fine_in       = fine_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      r2_in         = r2_ff;
      last_temp_in  = last_temp_ff;
      last_press_in = last_press_ff;
      temp_out_in   = temp_out_ff;
      press_out_in  = press_out_ff;
      hum_out_in    = hum_out_ff;
      th_in         = th_ff;
      ph_in         = ph_ff;
      finish        = 1'b0;
      fine_v        = '0;
      tc_v          = '0;
      num_v         = '0;
      pp_v          = '0;
      pr_v          = '0;
      u_v           = '0;
      y_v           = '0;
      tbad          = 1'b0;
      pbad          = 1'b0;

      // transfer in: latch raw readings
      if ((state_ff == SEQ_IDLE) && req.valid) begin
         rt_in   = req.raw_temp;
         rp_in   = req.raw_press;
         rh_in   = req.raw_hum;
         step_in = ST_T1;
      end

      if (consume) begin
         case (step_ff)
            ST_T1: begin
               r0_in   = res >>> 11;
               step_in = ST_T2;
            end
            ST_T2: begin
               r1_in   = res >>> 12;
               step_in = ST_T3;
            end
            // fine temperature and the temperature result
            ST_T3: begin
               fine_v  = r0_ff + (res >>> 14);
               fine_in = fine_v[24:0];
               tc_v    = ((fine_v <<< 2) + fine_v + T_RND) >>> 8;
               tbad    = (tc_v < TEMP_LO) || (tc_v > TEMP_HI);
               th_in   = tbad;
               if (tbad) begin
                  temp_out_in = last_temp_ff;
               end else begin
                  temp_out_in  = tc_v[14:0];
                  last_temp_in = tc_v[14:0];
               end
               step_in = ST_P1;
            end
            ST_P1: begin
               r0_in   = res;
               step_in = ST_P2;
            end
            ST_P2: begin
               r1_in   = res;
               step_in = ST_P3;
            end
            ST_P3: begin
               r1_in   = r1_ff + (res <<< 17) + (to_dp(36'(coeff.p4)) <<< 35);
               step_in = ST_P4;
            end
            ST_P4: begin
               r2_in   = res >>> 8;
               step_in = ST_P5;
            end
            ST_P5: begin
               r2_in   = BASE47 + r2_ff + (res <<< 12);
               step_in = ST_P6;
            end
            // divisor, then numerator with its range check
            ST_P6: begin
               r2_in = res >>> 33;
               num_v = (to_dp(36'(PP_BASE - {1'b0, rp_ff})) <<< 31) - r1_ff;
               pbad  = ((res >>> 33) == '0) || (num_v > NUM_LIM) || (num_v < -NUM_LIM);
               r0_in = num_v;
               if (pbad) begin
                  press_out_in = last_press_ff;
                  ph_in        = 1'b1;
                  step_in      = ST_H1;
               end else begin
                  step_in = ST_P7;
               end
            end
            ST_P7: begin
               r0_in   = res;
               step_in = ST_P8;
            end
            // truncating signed quotient from the magnitude divide
            ST_P8: begin
               pp_v  = (r0_ff[DP_W-1] ^ r2_ff[DP_W-1]) ? -res : res;
               r0_in = pp_v;
               pbad  = (pp_v >= PP_LIM) || (pp_v <= -PP_LIM);
               if (pbad) begin
                  press_out_in = last_press_ff;
                  ph_in        = 1'b1;
                  step_in      = ST_H1;
               end else begin
                  step_in = ST_P9;
               end
            end
            ST_P9: begin
               r1_in   = res;
               step_in = ST_P10;
            end
            ST_P10: begin
               r2_in   = res >>> 25;
               step_in = ST_P11;
            end
            // pressure result and range check
            ST_P11: begin
               pr_v = ((r0_ff + r2_ff + (res >>> 19)) >>> 8) +
                      (to_dp(36'(coeff.p7)) <<< 4);
               pbad = (pr_v < PRESS_LO) || (pr_v > PRESS_HI);
               ph_in = pbad;
               if (pbad) begin
                  press_out_in = last_press_ff;
               end else begin
                  press_out_in  = pr_v[24:0];
                  last_press_in = pr_v[24:0];
               end
               step_in = ST_H1;
            end
            ST_H1: begin
               r0_in = ((to_dp(36'(rh_ff)) <<< 14) - (to_dp(36'(coeff.h4)) <<< 20) -
                        res + H_RND1) >>> 15;
               step_in = ST_H2;
            end
            ST_H2: begin
               r1_in   = res >>> 10;
               step_in = ST_H3;
            end
            ST_H3: begin
               r2_in   = (res >>> 11) + H_OFS2;
               step_in = ST_H4;
            end
            ST_H4: begin
               r1_in   = (res >>> 10) + H_OFS3;
               step_in = ST_H5;
            end
            ST_H5: begin
               r1_in   = (res + H_RND2) >>> 14;
               step_in = ST_H6;
            end
            // raw humidity term; square correction only with a nonzero h1 and u below U_LIM
            ST_H6: begin
               r0_in = res;
               u_v   = abs_dp(res >>> 15);
               r1_in = u_v;
               if (coeff.h1 == 8'd0) begin
                  y_v        = res;
                  hum_out_in = hum_clamp(y_v);
                  finish     = 1'b1;
               end else if (u_v >= U_LIM) begin
                  y_v        = DP_ONE_N;
                  hum_out_in = hum_clamp(y_v);
                  finish     = 1'b1;
               end else begin
                  step_in = ST_H7;
               end
            end
            ST_H7: begin
               r1_in   = res >>> 7;
               step_in = ST_H8;
            end
            ST_H8: begin
               y_v        = (res >= SQ_LIM) ? DP_ONE_N : (r0_ff - (res >>> 4));
               hum_out_in = hum_clamp(y_v);
               finish     = 1'b1;
            end
            default: begin
               finish = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         last_temp_ff  <= '0;
         last_press_ff <= '0;
      end else begin
         state_ff      <= state_in;
         last_temp_ff  <= last_temp_in;
         last_press_ff <= last_press_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      rt_ff        <= rt_in;
      rp_ff        <= rp_in;
      rh_ff        <= rh_in;
      fine_ff      <= fine_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      r2_ff        <= r2_in;
      temp_out_ff  <= temp_out_in;
      press_out_ff <= press_out_in;
      hum_out_ff   <= hum_out_in;
      th_ff        <= th_in;
      ph_ff        <= ph_in;
   end

   assign rsp.temp_centi = temp_out_ff;
   assign rsp.press_q8   = press_out_ff;
   assign rsp.hum_q10    = hum_out_ff;
   assign rsp.temp_held  = th_ff;
   assign rsp.press_held = ph_ff;

endmodule

/* rtl/core/humidity_pressure_temp_compensation.sv */
`timescale 1ns / 1ps
// Temperature / pressure / humidity compensation. Each transfer on req carries raw
// 20-bit temperature, 20-bit pressure and 16-bit humidity readings; one transfer on rsp
// returns temperature in 0.01 degC, pressure in Pa * 256 and relative humidity in
// % * 1024 (clamped to 0..100 %). A temperature outside -40..85 degC, or a pressure
// outside 300..1100 hPa, with a zero divisor term or with an out-of-range numerator or
// quotient, repeats the last good value with its held flag set. Coefficients are to be
// written over the APB port (registers at 8-byte steps) while no item is in flight; the
// block itself does not enforce this. One item at a time: every product and the single
// quotient go through one shared shift-add/subtract unit at one bit per cycle, and the
// next item is accepted only after the result has transferred. A held pressure skips
// the remaining pressure steps, humidity without its square term skips its last two
// products, and a stalled result delays the next item.
// depends on hpt_pkg, hpt_req_if, hpt_rsp_if, hpt_alu, hpt_csr, hpt_seq
module humidity_pressure_temp_compensation (
   input  logic                             clock,
   input  logic                             reset,
   hpt_req_if.sink                          req,
   hpt_rsp_if.source                        rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hpt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hpt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hpt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import hpt_pkg::*;

   coeff_type            coeff;
   alu_ctl_type          alu_ctl;
   alu_rsp_type          alu_rsp;
   dp_type               alu_a;
   logic [ALU_B_W-1:0]   alu_b;

   // coefficient registers
   hpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coeff   (coeff)
   );

   // shared arithmetic unit
   hpt_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .a     (alu_a),
      .b     (alu_b),
      .rsp   (alu_rsp)
   );

   // sequencer and result registers
   hpt_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .coeff   (coeff),
      .alu_ctl (alu_ctl),
      .alu_a   (alu_a),
      .alu_b   (alu_b),
      .alu_rsp (alu_rsp)
   );

endmodule
